FILE: rtl/complex_arithmetic_unit_core_macros.svh
// Assertion macros for the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CAU_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CAU_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define CAU_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/cau_pkg.sv
// Shared types, operation codes and saturation helpers for the complex arithmetic unit.
package cau_pkg;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    localparam logic [2:0] CLS_ADD = 3'd0;
    localparam logic [2:0] CLS_SUB = 3'd1;
    localparam logic [2:0] CLS_MUL = 3'd2;
    localparam logic [2:0] CLS_DIV = 3'd3;
    localparam logic [2:0] CLS_DZ  = 3'd4;

    typedef struct packed {
        logic [2:0]         cls;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
    } cmd_t;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } sm_t;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    function automatic sm_t to_sm(input logic signed [64:0] v);
        sm_t s;
        logic [64:0] n;
        n = -v;
        s.neg = v[64];
        s.mag = v[64] ? n[63:0] : v[63:0];
        return s;
    endfunction

    function automatic sat_t sat32(input sm_t s);
        sat_t r;
        logic [63:0] lim;
        logic [63:0] m;
        logic [63:0] n;
        lim = s.neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        m = s.mag;
        r.ovf = 1'b0;
        if (m > lim) begin
            m = lim;
            r.ovf = 1'b1;
        end
        n = -m;
        r.val = s.neg ? n[31:0] : m[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/cau_front.sv
// Input stage: registers the incoming beat and classifies the operation.
module cau_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,   // kind
    input  logic [127:0]         s_tdata,   // a_real, a_imag, b_real, b_imag
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cau_pkg::cmd_t        cmd
);

    logic          valid_reg;
    cau_pkg::cmd_t cmd_reg;
    cau_pkg::cmd_t cmd_next;

    assign s_tready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next.ar = s_tdata[31:0];
        cmd_next.ai = s_tdata[63:32];
        cmd_next.br = s_tdata[95:64];
        cmd_next.bi = s_tdata[127:96];
        case (s_tuser)
            cau_pkg::KIND_ADD: cmd_next.cls = cau_pkg::CLS_ADD;
            cau_pkg::KIND_SUB: cmd_next.cls = cau_pkg::CLS_SUB;
            cau_pkg::KIND_MUL: cmd_next.cls = cau_pkg::CLS_MUL;
            default: begin
                cmd_next.cls = (s_tdata[127:64] == 64'd0) ? cau_pkg::CLS_DZ
                                                          : cau_pkg::CLS_DIV;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: rtl/cau_fifo.sv
// Small register queue between the front and back ends.
module cau_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/cau_div.sv
// Bit-serial restoring divider: round(num * 2^FRAC_BITS / den), large results saturated.
module cau_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num_mag,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] q_mag
);

    localparam int W     = 64 + FRAC_BITS;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     n_reg;
    logic [63:0]      r_reg;
    logic [63:0]      den_reg;
    logic [33:0]      q_reg;
    logic             big_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;
    logic [63:0] r_next;
    logic [64:0] twice_r;
    logic        rnd;

    assign trial   = {r_reg, n_reg[W-1]};
    assign ge      = trial >= {1'b0, den_reg};
    assign diff    = trial - {1'b0, den_reg};
    assign r_next  = ge ? diff[63:0] : trial[63:0];
    assign twice_r = {r_reg, 1'b0};
    assign rnd     = twice_r >= {1'b0, den_reg};
    assign done    = done_reg;
    assign q_mag   = big_reg ? '1 : (64'(q_reg) + 64'(rnd));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= W'(num_mag) << FRAC_BITS;
            den_reg <= den;
            r_reg   <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
        end else if (run_reg) begin
            n_reg   <= {n_reg[W-2:0], 1'b0};
            r_reg   <= r_next;
            q_reg   <= {q_reg[32:0], ge};
            big_reg <= big_reg | q_reg[33];
        end
    end

endmodule

FILE: rtl/cau_back.sv
// Execution back end: fast path for add/sub, shared multiplier, two serial dividers.
`include "complex_arithmetic_unit_core_macros.svh"
module cau_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cau_pkg::cmd_t cmd,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // res_real, res_imag
    output logic [1:0]    m_tuser    // overflow, div_by_zero
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_MEND   = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam logic [64:0] HALF = (65'd1 << FRAC_BITS) >> 1;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [2:0]         step_reg;
    cau_pkg::cmd_t      op_reg;
    logic signed [63:0] p_reg [6];
    cau_pkg::sm_t       res_re_reg;
    cau_pkg::sm_t       res_im_reg;

    logic               m_valid_reg;
    logic [63:0]        m_data_reg;
    logic [1:0]         m_user_reg;

    logic               out_free;
    logic               load_out;
    logic [63:0]        out_data;
    logic [1:0]         out_user;

    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [63:0] prod;
    logic [2:0]         last_step;

    logic signed [32:0] add_re;
    logic signed [32:0] add_im;
    cau_pkg::sat_t      fast_re;
    cau_pkg::sat_t      fast_im;
    cau_pkg::sat_t      slow_re;
    cau_pkg::sat_t      slow_im;

    cau_pkg::sm_t       mul_re;
    cau_pkg::sm_t       mul_im;
    logic [64:0]        sc_re;
    logic [64:0]        sc_im;
    cau_pkg::sm_t       num_re;
    cau_pkg::sm_t       num_im;
    logic [63:0]        den;

    logic               div_start;
    logic               done0;
    logic               done1;
    logic [63:0]        q0;
    logic [63:0]        q1;

    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign last_step = (op_reg.cls == cau_pkg::CLS_MUL) ? 3'd3 : 3'd5;
    assign div_start = (state_reg == ST_DSTART);

    always_comb begin
        case (step_reg)
            3'd0:    begin mx = op_reg.ar; my = op_reg.br; end
            3'd1:    begin mx = op_reg.ai; my = op_reg.bi; end
            3'd2:    begin mx = op_reg.ar; my = op_reg.bi; end
            3'd3:    begin mx = op_reg.ai; my = op_reg.br; end
            3'd4:    begin mx = op_reg.br; my = op_reg.br; end
            default: begin mx = op_reg.bi; my = op_reg.bi; end
        endcase
    end
    assign prod = mx * my;

    // fast path from the queue head
    always_comb begin
        if (cmd.cls == cau_pkg::CLS_SUB) begin
            add_re = {cmd.ar[31], cmd.ar} - {cmd.br[31], cmd.br};
            add_im = {cmd.ai[31], cmd.ai} - {cmd.bi[31], cmd.bi};
        end else begin
            add_re = {cmd.ar[31], cmd.ar} + {cmd.br[31], cmd.br};
            add_im = {cmd.ai[31], cmd.ai} + {cmd.bi[31], cmd.bi};
        end
        fast_re = cau_pkg::sat32(cau_pkg::to_sm({{32{add_re[32]}}, add_re}));
        fast_im = cau_pkg::sat32(cau_pkg::to_sm({{32{add_im[32]}}, add_im}));
    end

    always_comb begin
        mul_re = cau_pkg::to_sm({p_reg[0][63], p_reg[0]} - {p_reg[1][63], p_reg[1]});
        mul_im = cau_pkg::to_sm({p_reg[2][63], p_reg[2]} + {p_reg[3][63], p_reg[3]});
        sc_re  = ({1'b0, mul_re.mag} + HALF) >> FRAC_BITS;
        sc_im  = ({1'b0, mul_im.mag} + HALF) >> FRAC_BITS;
        num_re = cau_pkg::to_sm({p_reg[0][63], p_reg[0]} + {p_reg[1][63], p_reg[1]});
        num_im = cau_pkg::to_sm({p_reg[3][63], p_reg[3]} - {p_reg[2][63], p_reg[2]});
        den    = $unsigned(p_reg[4]) + $unsigned(p_reg[5]);
        slow_re = cau_pkg::sat32(res_re_reg);
        slow_im = cau_pkg::sat32(res_im_reg);
    end

    always_comb begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        load_out   = 1'b0;
        out_data   = {fast_im.val, fast_re.val};
        out_user   = {1'b0, fast_re.ovf | fast_im.ovf};
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.cls == cau_pkg::CLS_MUL || cmd.cls == cau_pkg::CLS_DIV) begin
                        cmd_ready  = 1'b1;
                        state_next = ST_MUL;
                    end else if (out_free) begin
                        cmd_ready = 1'b1;
                        load_out  = 1'b1;
                        if (cmd.cls == cau_pkg::CLS_DZ) begin
                            out_data = '0;
                            out_user = 2'b10;
                        end
                    end
                end
            end
            ST_MUL: begin
                if (step_reg == last_step) begin
                    state_next = (op_reg.cls == cau_pkg::CLS_MUL) ? ST_MEND : ST_DSTART;
                end
            end
            ST_MEND:   state_next = ST_OUT;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV: begin
                if (done0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                out_data = {slow_im.val, slow_re.val};
                out_user = {1'b0, slow_re.ovf | slow_im.ovf};
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= out_data;
            m_user_reg <= out_user;
        end
        if (state_reg == ST_IDLE) begin
            step_reg <= '0;
            op_reg   <= cmd;
        end else if (state_reg == ST_MUL) begin
            p_reg[step_reg] <= prod;
            step_reg        <= step_reg + 1'b1;
        end
        if (state_reg == ST_MEND) begin
            res_re_reg <= '{neg: mul_re.neg, mag: sc_re[63:0]};
            res_im_reg <= '{neg: mul_im.neg, mag: sc_im[63:0]};
        end else if (state_reg == ST_DSTART) begin
            res_re_reg.neg <= num_re.neg;
            res_im_reg.neg <= num_im.neg;
        end else if (state_reg == ST_DIV && done0) begin
            res_re_reg.mag <= q0;
            res_im_reg.mag <= q1;
        end
    end

    cau_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div_re (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_mag (num_re.mag),
        .den     (den),
        .done    (done0),
        .q_mag   (q0)
    );

    cau_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div_im (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_mag (num_im.mag),
        .den     (den),
        .done    (done1),
        .q_mag   (q1)
    );

    `CAU_ASSERT_IMPL(a_pop_has_item, aclk, aresetn, cmd_ready, cmd_valid)
    `CAU_ASSERT_IMPL(a_div_lockstep, aclk, aresetn, done0, done1)
    `CAU_ASSERT_NEXT(a_start_runs, aclk, aresetn, div_start, state_reg == ST_DIV)

endmodule

FILE: rtl/complex_arithmetic_unit_core.sv
// Complex arithmetic unit top level: front stage, command queue and execution back end.
//
// Input channel s_*: one beat carries kind in s_tuser (add, sub, mul, div) and the two
// complex operands A and B in s_tdata, signed fixed point with FRAC_BITS fraction bits.
// Result channel m_*: one beat per input beat, in input order, carrying the saturated
// result in m_tdata and the overflow and divide-by-zero flags in m_tuser.
// Add, subtract and zero-divisor divide take the back end's fast path, so a stream of
// them runs at one beat per cycle while m_tready stays high; each passes the front
// register, the queue and the output register. Multiply holds the back end for four
// products through the single 32x32 multiplier, a rounding state and the output state.
// Divide holds it for six products, a start state, then two bit-serial dividers that
// retire one quotient bit per cycle, and the output state.
// The front stage and a QUEUE_DEPTH entry queue keep accepting beats until full while
// the back end works or while the receiver stalls; m_* holds its beat until m_tready.
// Reset (aresetn low, synchronous) empties the queue and drops any beat in flight.
module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // kind
    input  logic [127:0] s_tdata,   // a_real, a_imag, b_real, b_imag
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_real, res_imag
    output logic [1:0]   m_tuser    // overflow, div_by_zero
);

    localparam int CMD_W = $bits(cau_pkg::cmd_t);

    logic          f_valid;
    logic          f_ready;
    cau_pkg::cmd_t f_cmd;
    logic          q_valid;
    logic          q_ready;
    logic [CMD_W-1:0] q_data;
    cau_pkg::cmd_t q_cmd;

    assign q_cmd = cau_pkg::cmd_t'(q_data);

    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    cau_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    cau_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: sim/complex_arithmetic_unit_core_test.sv
// Self-checking stream testbench for the complex arithmetic unit core.
module complex_arithmetic_unit_core_test;

    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               ovf;
        logic               dz;
    } cplx_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;   // kind
    logic [127:0] s_tdata;   // a_real, a_imag, b_real, b_imag
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // res_real, res_imag
    logic [1:0]   m_tuser;   // overflow, div_by_zero

    cplx_result_t pending_results[$];
    int errors = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;
    int kind_count[4] = '{0, 0, 0, 0};

    complex_arithmetic_unit_core #(.FRAC_BITS(FRAC)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] clip32(input logic neg, input logic [127:0] mag,
                                           inout logic ovf);
        logic [127:0] lim;
        logic [127:0] m;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        m = mag;
        if (m > lim) begin
            m = lim;
            ovf = 1'b1;
        end
        return neg ? -m[31:0] : m[31:0];
    endfunction

    function automatic logic [127:0] round_div(input logic [127:0] num, input logic [127:0] den);
        logic [127:0] q;
        logic [127:0] r;
        q = (num << FRAC) / den;
        r = (num << FRAC) % den;
        if (2 * r >= den) q = q + 1;
        return q;
    endfunction

    function automatic cplx_result_t predict_cplx(input logic [1:0] kind,
            input logic signed [31:0] ar, input logic signed [31:0] ai,
            input logic signed [31:0] br, input logic signed [31:0] bi);
        cplx_result_t res;
        logic signed [127:0] xr, xi, den;
        logic [127:0] mr, mi;
        logic nr, ni;
        logic ovf;
        ovf = 1'b0;
        res.dz = 1'b0;
        den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
        case (kind)
            cau_pkg::KIND_ADD: begin xr = 128'(ar) + 128'(br); xi = 128'(ai) + 128'(bi); end
            cau_pkg::KIND_SUB: begin xr = 128'(ar) - 128'(br); xi = 128'(ai) - 128'(bi); end
            cau_pkg::KIND_MUL: begin
                xr = 128'(ar) * 128'(br) - 128'(ai) * 128'(bi);
                xi = 128'(ar) * 128'(bi) + 128'(ai) * 128'(br);
            end
            default: begin
                xr = 128'(ar) * 128'(br) + 128'(ai) * 128'(bi);
                xi = 128'(ai) * 128'(br) - 128'(ar) * 128'(bi);
            end
        endcase
        nr = xr < 0;
        ni = xi < 0;
        mr = nr ? -xr : xr;
        mi = ni ? -xi : xi;
        if (kind == cau_pkg::KIND_MUL) begin
            mr = (mr + (128'd1 << (FRAC - 1))) >> FRAC;
            mi = (mi + (128'd1 << (FRAC - 1))) >> FRAC;
        end else if (kind == cau_pkg::KIND_DIV) begin
            if (den == 0) begin
                res.dz = 1'b1;
                mr = 0;
                mi = 0;
            end else begin
                mr = round_div(mr, den);
                mi = round_div(mi, den);
            end
        end
        if (mr == 0) nr = 1'b0;
        if (mi == 0) ni = 1'b0;
        res.re = clip32(nr, mr, ovf);
        res.im = clip32(ni, mi, ovf);
        res.ovf = ovf;
        return res;
    endfunction

    task automatic send_beat(input logic [1:0] kind, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {bi, br, ai, ar};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_cplx(kind, ar, ai, br, bi));
        kind_count[kind]++;
        beats_sent++;
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(131072 * 4)) - 262144);
            3: return 32'($signed($urandom_range(65536 * 64)) - 2097152);
            4: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edges[5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000,
                                  32'hFFFF_FFFF};
        for (int k = 0; k < 4; k++) begin
            send_beat(k[1:0], edges[0], edges[1], edges[1], edges[0]);
            send_beat(k[1:0], edges[1], edges[0], edges[3], edges[4]);
            send_beat(k[1:0], edges[3], edges[3], edges[3], edges[3]);
            send_beat(k[1:0], edges[4], edges[0], edges[2], edges[4]);
        end
        // zero divisor, with nonzero and zero dividends
        send_beat(cau_pkg::KIND_DIV, edges[0], edges[1], 32'h0, 32'h0);
        send_beat(cau_pkg::KIND_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
        // rounding ties: 0.5 * 2^-16 products and 1/3; then a quotient that overflows
        send_beat(cau_pkg::KIND_MUL, 32'h1, 32'h0, 32'h0000_8000, 32'h0);
        send_beat(cau_pkg::KIND_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0);
        send_beat(cau_pkg::KIND_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
        send_beat(cau_pkg::KIND_DIV, 32'h0, 32'h0001_0000, 32'h0, 32'h1);
        pause_until_drained();
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle = idle;
        recv_stall = stall;
        for (int n = 0; n < count; n++)
            send_beat(2'($urandom_range(3)), rand_part(), rand_part(),
                      ($urandom_range(15) == 0) ? 32'h0 : rand_part(),
                      ($urandom_range(15) == 0) ? 32'h0 : rand_part());
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        cplx_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                beats_checked++;
                if (m_tdata[31:0] !== exp_res.re) begin
                    $error("res_real expected %h got %h", exp_res.re, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== exp_res.im) begin
                    $error("res_imag expected %h got %h", exp_res.im, m_tdata[63:32]);
                    errors++;
                end
                if (m_tuser[0] !== exp_res.ovf) begin
                    $error("overflow expected %b got %b", exp_res.ovf, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== exp_res.dz) begin
                    $error("div_by_zero expected %b got %b", exp_res.dz, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(160, 0, 0);
        test_random(160, 53, 0);
        pause_until_drained();
        test_random(160, 0, 53);
        test_random(170, 9, 9);
        send_idle = 0;
        recv_stall = 0;
        pause_until_drained();
        repeat (200) @(posedge aclk);
        $display("Sent %0d beats (add %0d, sub %0d, mul %0d, div %0d), checked %0d results",
                 beats_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
                 beats_checked);
        $display("Phases: directed edges, free flow, sender gaps, receiver stalls, mixed");
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: complex_arithmetic_unit_core.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_fifo.sv
rtl/cau_div.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit_core.sv
sim/complex_arithmetic_unit_core_test.sv
